>>> rtl/ws2_pkg.sv
// ----------------------------------------------------------------------------
// ws2_pkg: shared types and constants for the single-wire LED pulse encoder
// Request and result payloads, command codes, register indexes, bit-phase
// encoding and the tick-count loader.
// ----------------------------------------------------------------------------
package ws2_pkg;

  // Width of the phase tick counter (10 to 32)
  localparam int COUNT_BITS = 16;
  localparam logic [32:0] CNT_MAX = (33'd1 << COUNT_BITS) - 33'd1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};

  // Command codes on the input channel
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_LATCH = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_ONE_HIGH  = 3'd0;
  localparam logic [2:0] REG_ONE_LOW   = 3'd1;
  localparam logic [2:0] REG_ZERO_HIGH = 3'd2;
  localparam logic [2:0] REG_ZERO_LOW  = 3'd3;
  localparam logic [2:0] REG_LATCH     = 3'd4;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic pin_level;
    logic busy_res;
    logic accepted;
    logic byte_done;
    logic holding_full;
  } out_item_t;

  // Classified operation handed from the front end to the back end
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_LATCH = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } q_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_HIGH  = 2'd1,
    PH_LOW   = 2'd2,
    PH_LATCH = 2'd3
  } phase_t;

  typedef struct packed {
    logic [9:0]  one_high_ticks;
    logic [9:0]  one_low_ticks;
    logic [9:0]  zero_high_ticks;
    logic [9:0]  zero_low_ticks;
    logic [15:0] latch_ticks;
  } cfg_t;

  // Tick count for a phase: zero acts as one, oversize saturates
  function automatic logic [COUNT_BITS-1:0] load_count(input logic [15:0] v);
    logic [32:0] w;
    w = {17'd0, v};
    if (v == 16'd0) w = 33'd1;
    if (w > CNT_MAX) w = CNT_MAX;
    return w[COUNT_BITS-1:0];
  endfunction

endpackage

>>> rtl/ws2_queue.sv
// ----------------------------------------------------------------------------
// ws2_queue: two-entry request queue
// Decouples the front-end classifier from the pulse back end.
// ----------------------------------------------------------------------------
module ws2_queue
  import ws2_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t push_item,
  input  logic    pop,
  output q_item_t head_item,
  output q_stat_t stat
);

  q_item_t    entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  assign head_item  = entry_r[rd_ptr_r];
  assign stat.full  = (count_r == 2'd2);
  assign stat.empty = (count_r == 2'd0);

endmodule

>>> rtl/ws2_front.sv
// ----------------------------------------------------------------------------
// ws2_front: request intake and classification
// Decode the command field and push the request into the queue.
// ----------------------------------------------------------------------------
module ws2_front
  import ws2_pkg::*;
(
  input  in_item_t in_data,
  input  logic     in_valid,
  output logic     in_stall,
  input  q_stat_t  q_stat,
  output logic     push,
  output q_item_t  push_item
);

  op_t op;

  // Map command codes; the unused code becomes a no-op
  always_comb begin
    unique case (in_data.cmd)
      CMD_TICK:  op = OP_TICK;
      CMD_LOAD:  op = OP_LOAD;
      CMD_LATCH: op = OP_LATCH;
      default:   op = OP_NOP;
    endcase
  end

  assign in_stall       = q_stat.full;
  assign push           = in_valid && !q_stat.full;
  assign push_item.op   = op;
  assign push_item.data = in_data.data_byte;

endmodule

>>> rtl/ws2_back.sv
// ----------------------------------------------------------------------------
// ws2_back: pulse sequencer and result register
// Execute one queued request per cycle unless the held result is stalled, and hold its result for the receiver.
// ----------------------------------------------------------------------------
module ws2_back
  import ws2_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  q_stat_t   q_stat,
  input  q_item_t   head_item,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  phase_t                phase_r, phase_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt, count_dec;
  logic [7:0]            shift_r, shift_nxt, shift_dec;
  logic [3:0]            bits_r, bits_nxt, bits_dec;
  logic [7:0]            held_byte_r, held_byte_nxt;
  logic                  held_valid_r, held_valid_nxt;
  logic                  pin_r, pin_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;
  logic                  acc, done;

  // Advance when a request waits and the result slot is free or draining
  assign pop = !q_stat.empty && (!out_valid_r || !out_stall);

  assign count_dec = (count_r != '0) ? count_r - CNT_ONE : '0;
  assign shift_dec = {shift_r[6:0], 1'b0};
  assign bits_dec  = (bits_r != 4'd0) ? bits_r - 4'd1 : 4'd0;

  always_comb begin
    phase_nxt      = phase_r;
    count_nxt      = count_r;
    shift_nxt      = shift_r;
    bits_nxt       = bits_r;
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    pin_nxt        = pin_r;
    acc            = 1'b0;
    done           = 1'b0;
    if (pop) begin
      unique case (head_item.op)
        OP_TICK: begin
          acc = 1'b1;
          if (phase_r != PH_IDLE) begin
            count_nxt = count_dec;
            if (count_dec == '0) begin
              unique case (phase_r)
                PH_HIGH: begin
                  phase_nxt = PH_LOW;
                  count_nxt = shift_r[7] ? load_count({6'd0, cfg.one_low_ticks})
                                         : load_count({6'd0, cfg.zero_low_ticks});
                  pin_nxt   = 1'b0;
                end
                PH_LOW: begin
                  shift_nxt = shift_dec;
                  bits_nxt  = bits_dec;
                  if (bits_dec != 4'd0) begin
                    phase_nxt = PH_HIGH;
                    count_nxt = shift_dec[7] ? load_count({6'd0, cfg.one_high_ticks})
                                             : load_count({6'd0, cfg.zero_high_ticks});
                    pin_nxt   = 1'b1;
                  end else begin
                    done = 1'b1;
                  end
                end
                default: begin
                end
              endcase
              // End of byte or latch gap: start the held byte or drop to idle
              if ((phase_r == PH_LOW && bits_dec == 4'd0) || phase_r == PH_LATCH) begin
                if (held_valid_r) begin
                  held_valid_nxt = 1'b0;
                  shift_nxt      = held_byte_r;
                  bits_nxt       = 4'd8;
                  phase_nxt      = PH_HIGH;
                  count_nxt      = held_byte_r[7] ? load_count({6'd0, cfg.one_high_ticks})
                                                  : load_count({6'd0, cfg.zero_high_ticks});
                  pin_nxt        = 1'b1;
                end else begin
                  phase_nxt = PH_IDLE;
                  count_nxt = '0;
                  bits_nxt  = 4'd0;
                  pin_nxt   = 1'b0;
                end
              end
            end
          end
        end
        OP_LOAD: begin
          if (phase_r == PH_IDLE) begin
            acc       = 1'b1;
            shift_nxt = head_item.data;
            bits_nxt  = 4'd8;
            phase_nxt = PH_HIGH;
            count_nxt = head_item.data[7] ? load_count({6'd0, cfg.one_high_ticks})
                                          : load_count({6'd0, cfg.zero_high_ticks});
            pin_nxt   = 1'b1;
          end else if (!held_valid_r) begin
            acc            = 1'b1;
            held_byte_nxt  = head_item.data;
            held_valid_nxt = 1'b1;
          end
        end
        OP_LATCH: begin
          if (phase_r == PH_IDLE && !held_valid_r) begin
            acc       = 1'b1;
            phase_nxt = PH_LATCH;
            count_nxt = load_count(cfg.latch_ticks);
            pin_nxt   = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end

    out_valid_nxt = pop ? 1'b1 : (out_valid_r && out_stall);
    out_data_nxt  = out_data_r;
    if (pop) begin
      out_data_nxt.pin_level    = pin_nxt;
      out_data_nxt.busy_res     = (phase_nxt != PH_IDLE);
      out_data_nxt.accepted     = acc;
      out_data_nxt.byte_done    = done;
      out_data_nxt.holding_full = held_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      count_r      <= '0;
      shift_r      <= 8'd0;
      bits_r       <= 4'd0;
      held_valid_r <= 1'b0;
      pin_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      count_r      <= count_nxt;
      shift_r      <= shift_nxt;
      bits_r       <= bits_nxt;
      held_valid_r <= held_valid_nxt;
      pin_r        <= pin_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_byte_r <= held_byte_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/ws2812_pulse_encoder.sv
// ----------------------------------------------------------------------------
// ws2812_pulse_encoder: single-wire LED pulse-code driver
// Front-end classifier, two-entry request queue and pulse back end.
// ----------------------------------------------------------------------------
// Usage:
//   Each input request (in_valid/in_stall, payload in_data) is one tick of
//   waveform time, a byte load or a latch request. Every request yields
//   exactly one result (out_valid/out_stall, payload out_data) carrying the
//   pin level after the request and the busy, accepted, byte_done and
//   holding_full flags. A request is taken on an edge with valid high and
//   stall low, on both channels.
//   An accepted request passes through the queue entry and then the
//   back-end result register. Throughput: one request per cycle while
//   out_stall is low; a stalled result blocks the back end.
//   When the receiver stalls, the result register holds, the queue fills
//   (two entries) and in_stall rises on the cycle the queue is full.
//   Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
//   ready; write tick counts only while no request is in flight.
//   Synchronous active-low reset: pin low, phase idle, holding register
//   empty, queue empty, tick counts back to 70/60/35/80/8000.
// ----------------------------------------------------------------------------
module ws2812_pulse_encoder
  import ws2_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t    cfg_r, cfg_nxt;
  q_stat_t q_stat;
  q_item_t push_item, head_item;
  logic    push, pop;

  assign cfg_ready = 1'b1;

  // Register writes; indexes past the list are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_ONE_HIGH:  cfg_nxt.one_high_ticks  = cfg_data[9:0];
        REG_ONE_LOW:   cfg_nxt.one_low_ticks   = cfg_data[9:0];
        REG_ZERO_HIGH: cfg_nxt.zero_high_ticks = cfg_data[9:0];
        REG_ZERO_LOW:  cfg_nxt.zero_low_ticks  = cfg_data[9:0];
        REG_LATCH:     cfg_nxt.latch_ticks     = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.one_high_ticks  <= 10'd70;
      cfg_r.one_low_ticks   <= 10'd60;
      cfg_r.zero_high_ticks <= 10'd35;
      cfg_r.zero_low_ticks  <= 10'd80;
      cfg_r.latch_ticks     <= 16'd8000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ws2_front u_front (
    .in_data   (in_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  ws2_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .stat      (q_stat)
  );

  ws2_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_stat    (q_stat),
    .head_item (head_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A high pin only occurs inside a bit
  a_pin_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.pin_level |-> out_data.busy_res)
    else $error("pin high while encoder idle");

  // A waiting byte always sits behind an active bit or gap
  a_held_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.holding_full |-> out_data.busy_res)
    else $error("holding register full while idle");

  // Byte completion is only reported on an accepted tick
  a_done_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.byte_done |-> out_data.accepted)
    else $error("byte_done without accepted tick");

  // A request pushed into an empty queue reaches the back end next cycle
  a_queue_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    push && q_stat.empty |=> !q_stat.empty)
    else $error("queue lost a request");

endmodule

>>> verif/ws2812_wave_checker.sv
// ----------------------------------------------------------------------------
// ws2812_wave_checker: result checker for the single-wire LED pulse encoder
// Watches the request, result and register-write channels. Keeps its own
// copy of the tick settings and the waveform state, works out the expected
// result of every accepted request, and compares each accepted result, field
// by field, with the oldest one still due.
// ----------------------------------------------------------------------------
module ws2812_wave_checker
  import ws2_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          pending,
  output int          requests_seen,
  output int          results_seen,
  output int          bytes_seen,
  output int          latches_seen
);

  localparam logic [63:0] COUNT_TOP = (64'd1 << COUNT_BITS) - 64'd1;

  // tick settings
  logic [9:0]  one_hi, one_lo, zero_hi, zero_lo;
  logic [15:0] gap_len;

  // waveform state
  logic [7:0]            shifter;
  logic [3:0]            bits_left;
  phase_t                wave_phase;
  logic [COUNT_BITS-1:0] ticks_left;
  logic [7:0]            held_byte;
  logic                  held_full;
  logic                  pin;

  out_item_t due_results[$];

  // zero counts as one tick, oversize clips to the counter's top
  function automatic logic [COUNT_BITS-1:0] tick_len(input logic [15:0] setting);
    logic [63:0] n;
    n = {48'd0, setting};
    if (setting == 16'd0) n = 64'd1;
    if (n > COUNT_TOP) n = COUNT_TOP;
    return n[COUNT_BITS-1:0];
  endfunction

  task automatic begin_bit();
    wave_phase = PH_HIGH;
    ticks_left = tick_len(shifter[7] ? {6'd0, one_hi} : {6'd0, zero_hi});
    pin = 1'b1;
  endtask

  task automatic begin_byte(input logic [7:0] b);
    shifter = b;
    bits_left = 4'd8;
    begin_bit();
  endtask

  task automatic next_byte_or_idle();
    if (held_full) begin
      held_full = 1'b0;
      begin_byte(held_byte);
    end else begin
      wave_phase = PH_IDLE;
      ticks_left = '0;
      bits_left = 4'd0;
      pin = 1'b0;
    end
  endtask

  task automatic advance_tick(output logic finished);
    finished = 1'b0;
    if (wave_phase == PH_IDLE) return;
    if (ticks_left != '0) ticks_left = ticks_left - CNT_ONE;
    if (ticks_left != '0) return;
    case (wave_phase)
      PH_HIGH: begin
        wave_phase = PH_LOW;
        ticks_left = tick_len(shifter[7] ? {6'd0, one_lo} : {6'd0, zero_lo});
        pin = 1'b0;
      end
      PH_LOW: begin
        shifter = shifter << 1;
        if (bits_left != 4'd0) bits_left = bits_left - 4'd1;
        if (bits_left != 4'd0) begin
          begin_bit();
        end else begin
          finished = 1'b1;
          bytes_seen++;
          next_byte_or_idle();
        end
      end
      default: next_byte_or_idle();
    endcase
  endtask

  task automatic encode_request(input in_item_t req, output out_item_t res);
    logic took;
    logic finished;
    took = 1'b0;
    finished = 1'b0;
    case (req.cmd)
      CMD_TICK: begin
        took = 1'b1;
        advance_tick(finished);
      end
      CMD_LOAD: begin
        if (wave_phase == PH_IDLE) begin
          begin_byte(req.data_byte);
          took = 1'b1;
        end else if (!held_full) begin
          held_byte = req.data_byte;
          held_full = 1'b1;
          took = 1'b1;
        end
      end
      CMD_LATCH: begin
        if (wave_phase == PH_IDLE && !held_full) begin
          wave_phase = PH_LATCH;
          ticks_left = tick_len(gap_len);
          pin = 1'b0;
          took = 1'b1;
          latches_seen++;
        end
      end
      default: ;
    endcase
    res.pin_level    = pin;
    res.busy_res     = (wave_phase != PH_IDLE);
    res.accepted     = took;
    res.byte_done    = finished;
    res.holding_full = held_full;
  endtask

  task automatic check_field(input string name, input logic want, input logic got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      one_hi = 10'd70;
      one_lo = 10'd60;
      zero_hi = 10'd35;
      zero_lo = 10'd80;
      gap_len = 16'd8000;
      shifter = 8'd0;
      bits_left = 4'd0;
      wave_phase = PH_IDLE;
      ticks_left = '0;
      held_byte = 8'd0;
      held_full = 1'b0;
      pin = 1'b0;
      due_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ONE_HIGH:  one_hi = cfg_data[9:0];
          REG_ONE_LOW:   one_lo = cfg_data[9:0];
          REG_ZERO_HIGH: zero_hi = cfg_data[9:0];
          REG_ZERO_LOW:  zero_lo = cfg_data[9:0];
          REG_LATCH:     gap_len = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        encode_request(in_data, want);
        due_results.push_back(want);
        requests_seen++;
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (due_results.size() == 0) begin
          $display("%0t: result with nothing expected, got %b", $time, out_data);
          errors++;
        end else begin
          want = due_results.pop_front();
          check_field("pin_level", want.pin_level, out_data.pin_level);
          check_field("busy_res", want.busy_res, out_data.busy_res);
          check_field("accepted", want.accepted, out_data.accepted);
          check_field("byte_done", want.byte_done, out_data.byte_done);
          check_field("holding_full", want.holding_full, out_data.holding_full);
        end
      end
    end
    pending = due_results.size();
  end

endmodule

>>> verif/tb_ws2812_pulse_encoder.sv
// ----------------------------------------------------------------------------
// tb_ws2812_pulse_encoder: testbench for the single-wire LED pulse encoder
// Drives ticks, byte loads and latch requests under several tick settings,
// from one-tick phases up to the widest counts, with random gaps on the
// request side and random stalls on the result side. A checker beside the
// block predicts every result and counts mismatches; this top makes the
// stimulus, runs a no-progress watchdog and gives the verdict.
// ----------------------------------------------------------------------------
module tb_ws2812_pulse_encoder
  import ws2_pkg::*;
();

  // command code the block must ignore
  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  // register index with no register behind it
  localparam logic [2:0] REG_SPARE   = 3'd7;
  // request-to-result latency of the block
  localparam int         RESULT_LAG  = 2;
  // cycles with no handshake on any channel before the run is called hung
  localparam int         STALL_LIMIT = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int errors;
  int pending;
  int requests_seen;
  int results_seen;
  int bytes_seen;
  int latches_seen;
  int idle_cycles = 0;
  // when set, both sides run flat out with no gaps or stalls
  bit calm = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  ws2812_pulse_encoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ws2812_wave_checker wave_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .errors        (errors),
    .pending       (pending),
    .requests_seen (requests_seen),
    .results_seen  (results_seen),
    .bytes_seen    (bytes_seen),
    .latches_seen  (latches_seen)
  );

  // Half the draws give no wait at all, the rest a nonzero random wait; with calm set, none wait.
  function automatic int draw_gap();
    if (calm) return 0;
    return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
  endfunction

  function automatic in_item_t make_req(input logic [1:0] c, input logic [7:0] d);
    in_item_t r;
    r.cmd = c;
    r.data_byte = d;
    return r;
  endfunction

  // Mostly ticks so bytes and latch gaps actually run to completion; loads
  // and latches land on every phase, some of them refused.
  function automatic in_item_t random_request();
    int pick;
    logic [1:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 70) c = CMD_TICK;
    else if (pick < 88) c = CMD_LOAD;
    else if (pick < 95) c = CMD_LATCH;
    else c = CMD_UNUSED;
    return make_req(c, 8'($urandom));
  endfunction

  // Hold the request until it is taken. Called at a falling edge, returns at
  // one; valid stays high so the next request can follow with no bubble.
  task automatic push_request(input in_item_t req);
    int gap;
    gap = draw_gap();
    if ($urandom_range(0, 49) == 0) calm = !calm;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) push_request(make_req(CMD_TICK, 8'($urandom)));
  endtask

  // Ignored commands do not count toward the total.
  task automatic run_random(input int n);
    int sent;
    in_item_t req;
    sent = 0;
    while (sent < n) begin
      req = random_request();
      push_request(req);
      if (req.cmd != CMD_UNUSED) sent++;
    end
  endtask

  // Drop valid and wait until every result is back, then let the pipe empty.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (RESULT_LAG + 2) @(negedge clk);
  endtask

  // Write all five tick settings back to back, plus the unmapped index,
  // which must change nothing.
  task automatic program_timing(input logic [15:0] oh, input logic [15:0] ol,
                                input logic [15:0] zh, input logic [15:0] zl,
                                input logic [15:0] lt);
    logic [15:0] vals [6];
    logic [2:0]  idx [6];
    drain();
    vals = '{oh, ol, zh, zl, lt, 16'($urandom)};
    idx = '{REG_ONE_HIGH, REG_ONE_LOW, REG_ZERO_HIGH, REG_ZERO_LOW, REG_LATCH, REG_SPARE};
    for (int k = 0; k < 6; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= vals[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Small bit-phase count with random junk in the bits above the register.
  function automatic logic [15:0] short_count();
    return {6'($urandom), 10'($urandom_range(1, 6))};
  endfunction

  // Result side: before each result, hold out_stall for a draw_gap wait (which may be none),
  // then take it as soon as it shows up.
  initial begin
    int hold;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      hold = draw_gap();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Watchdog: any handshake counts as progress.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    // hold reset low from the start, release at a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. An unused code and a bare tick on an idle block change
    // nothing; these run on the reset tick settings.
    push_request(make_req(CMD_UNUSED, 8'hFF));
    push_request(make_req(CMD_TICK, 8'h00));

    // One-tick bit phases, two-tick latch gap.
    program_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd2);
    push_request(make_req(CMD_LATCH, 8'h5A));   // taken: idle and nothing held
    push_request(make_req(CMD_LATCH, 8'hA5));   // refused: gap in progress
    push_request(make_req(CMD_LOAD, 8'hFF));    // parked in the holding register
    push_request(make_req(CMD_LOAD, 8'h00));    // refused: holding register full
    push_request(make_req(CMD_LATCH, 8'h00));   // refused: busy and byte waiting
    send_ticks(2);                              // gap ends, held byte starts at once
    push_request(make_req(CMD_LOAD, 8'h00));    // parked behind the running byte
    push_request(make_req(CMD_UNUSED, 8'h00));  // ignored while busy
    send_ticks(16);                             // all-ones byte ends, zero byte follows

    // Random part: shortest phases first, then zero settings (which must act
    // as one tick; high bits above the register are dropped), then a few
    // random short settings.
    program_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
    run_random(90);
    program_timing({6'h3F, 10'd0}, 16'hFC00, 16'h0400, 16'h0000, 16'd0);
    run_random(70);
    repeat (3) begin
      program_timing(short_count(), short_count(), short_count(), short_count(),
                     16'($urandom_range(1, 8)));
      run_random(60);
    end

    // Widest counts: a few ticks into 1023-tick phases, then the widest low
    // and latch settings with a load and a latch request on top.
    program_timing(16'd1023, 16'd1, 16'd1, 16'd1023, 16'd1);
    push_request(make_req(CMD_LOAD, 8'h80));
    send_ticks(6);
    program_timing(16'd1, 16'd1023, 16'd1023, 16'd1, 16'hFFFF);
    push_request(make_req(CMD_LOAD, 8'h80));
    push_request(make_req(CMD_LATCH, 8'h00));
    send_ticks(6);

    drain();
    $display("run: %0d requests, %0d results checked", requests_seen, results_seen);
    $display("run: %0d bytes shifted out, %0d latch gaps, 9 tick settings",
             bytes_seen, latches_seen);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
